// ===== hdl/crsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crsc_pkg;

    localparam int DATA_W      = 32;
    localparam int KIND_W      = 4;
    localparam int DEPTH_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int MAG_W       = 65;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 4'd0,
        KIND_PUSHZ = 4'd1,
        KIND_ADD  = 4'd2,
        KIND_SUB  = 4'd3,
        KIND_MUL  = 4'd4,
        KIND_DIV  = 4'd5,
        KIND_DUP  = 4'd6,
        KIND_DROP = 4'd7,
        KIND_CONJ = 4'd8,
        KIND_NEG  = 4'd9
    } kind_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_RE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_IM = 1'd1;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Apply sign to a magnitude and clamp; returns {saturated, value}.
    function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] lim;
        logic [DATA_W:0]  res;
        lim = MAG_W'(VAL_MIN);
        if (neg) begin
            if (mag >= lim) begin
                res = {(mag > lim), VAL_MIN};
            end else begin
                res = {1'b0, -mag[DATA_W-1:0]};
            end
        end else begin
            if (mag > MAG_W'(VAL_MAX)) begin
                res = {1'b1, VAL_MAX};
            end else begin
                res = {1'b0, mag[DATA_W-1:0]};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crsc_stack_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crsc_stack_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/crsc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: ((mag << FRAC_BITS) / den), rounded, signed and clamped.
module crsc_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic                       neg,
    input  wire logic [63:0]                mag,
    input  wire logic [63:0]                den,
    output logic                            done,
    output logic                            sat,
    output logic signed [crsc_pkg::DATA_W-1:0] quot
);
    import crsc_pkg::*;

    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int HI_W  = NUM_W - DATA_W;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t                 state_reg;
    logic [63:0]             rem_reg;
    logic [DATA_W-1:0]       lo_reg;
    logic [DATA_W-1:0]       q_reg;
    logic [4:0]              cnt_reg;
    logic                    big_reg;
    logic                    neg_reg;
    logic [63:0]             den_reg;

    logic [NUM_W-1:0]        num;
    logic [HI_W-1:0]         num_hi;
    logic [64:0]             rem2;
    logic                    ge;
    logic [64:0]             rem_sub;
    logic                    round_up;
    logic [DATA_W:0]         q_rnd;
    logic [DATA_W:0]         clamped;

    assign num      = {mag, {FRAC_BITS{1'b0}}};
    assign num_hi   = num[NUM_W-1:DATA_W];
    assign rem2     = {rem_reg, lo_reg[DATA_W-1]};
    assign ge       = rem2 >= {1'b0, den_reg};
    assign rem_sub  = rem2 - {1'b0, den_reg};
    assign round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign q_rnd    = {1'b0, q_reg} + (DATA_W+1)'(round_up);
    assign clamped  = sat_mag(neg_reg, MAG_W'(q_rnd));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done      <= 1'b0;
        end else begin
            unique case (state_reg)
                D_IDLE: begin
                    done <= 1'b0;
                    if (start) begin
                        neg_reg <= neg;
                        den_reg <= den;
                        rem_reg <= 64'(num_hi);
                        lo_reg  <= num[DATA_W-1:0];
                        cnt_reg <= '0;
                        // quotient would not fit in 32 bits
                        big_reg <= 64'(num_hi) >= den;
                        state_reg <= (64'(num_hi) >= den) ? D_FIN : D_RUN;
                    end
                end
                D_RUN: begin
                    done    <= 1'b0;
                    rem_reg <= ge ? rem_sub[63:0] : rem2[63:0];
                    q_reg   <= {q_reg[DATA_W-2:0], ge};
                    lo_reg  <= {lo_reg[DATA_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DATA_W - 1)) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (big_reg) begin
                        quot <= neg_reg ? VAL_MIN : VAL_MAX;
                        sat  <= 1'b1;
                    end else begin
                        quot <= clamped[DATA_W-1:0];
                        sat  <= clamped[DATA_W];
                    end
                    done      <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: begin
                    done      <= 1'b0;
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/complex_rpn_stack_calculator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                          Handshake
// input     s_kind, s_literal_re/im, s_first_token         s_valid / s_ready
// result    m_top_re/im, m_depth, m_status                  m_valid / m_ready
// config    cfg_index, cfg_data                             cfg_we (no wait)
//
// One token at a time. A division makes two 32-step passes of the shared divider,
// real part then imaginary part; a pass ends early when its quotient overflows,
// and a zero divisor skips the divider.
// The stack lives in a one-port-read, one-port-write synchronous RAM.
// Reset clears stack pointer, config and handshake state; the RAM is not cleared.
// A waiting result does not block acceptance of the next token; that token
// stalls at its own result until the earlier one is taken.
module complex_rpn_stack_calculator #(
    parameter int STACK_DEPTH = crsc_pkg::DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = crsc_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [crsc_pkg::KIND_W-1:0]          s_kind,
    input  wire logic signed [crsc_pkg::DATA_W-1:0]   s_literal_re,
    input  wire logic signed [crsc_pkg::DATA_W-1:0]   s_literal_im,
    input  wire logic                                 s_first_token,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [crsc_pkg::DATA_W-1:0]        m_top_re,
    output logic signed [crsc_pkg::DATA_W-1:0]        m_top_im,
    output logic [crsc_pkg::DEPTH_W-1:0]              m_depth,
    output logic [crsc_pkg::STATUS_W-1:0]             m_status,
    input  wire logic                                 cfg_we,
    input  wire logic [crsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [crsc_pkg::DATA_W-1:0]          cfg_data
);
    import crsc_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SW  = 66;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_GET_TOP, S_GET_SEC, S_ADDSUB, S_MUL, S_SUM,
        S_MUL_RND, S_DIV_CHK, S_DIV_RE, S_DIV_RE_W, S_DIV_IM, S_DIV_IM_W,
        S_WR, S_TOP_RD, S_CAP
    } state_t;

    state_t                    state_reg;
    kind_t                     kind_reg;
    logic signed [DATA_W-1:0]  lit_re_reg, lit_im_reg;
    logic signed [DATA_W-1:0]  point_re_reg, point_im_reg;
    logic [SPW-1:0]            sp_reg;
    logic [AW-1:0]             wr_addr_reg;
    logic [STATUS_W-1:0]       stat_reg;
    logic                      sat_reg;
    logic signed [DATA_W-1:0]  a_reg, b_reg, c_reg, d_reg;
    logic signed [DATA_W-1:0]  res_re_reg, res_im_reg;
    logic [2:0]                step_reg;
    logic signed [63:0]        prod_reg;
    logic signed [63:0]        prods_reg [6];
    logic signed [SW-1:0]      sre_reg, sim_reg;
    logic [63:0]               den_reg;

    // memory
    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [2*DATA_W-1:0]       mem_rdata;

    logic [SPW-1:0]            sp_m1, sp_m2;
    logic signed [DATA_W-1:0]  rd_re, rd_im;
    logic signed [DATA_W-1:0]  mul_x, mul_y;
    logic [2:0]                n_prod;
    logic                      cap_fire;

    logic                      re_neg, im_neg;
    logic [MAG_W-1:0]          re_mag, im_mag;
    logic [MAG_W-1:0]          re_rnd, im_rnd;
    logic [DATA_W:0]           re_cl, im_cl;
    logic signed [DATA_W:0]    add_re, add_im;
    logic signed [DATA_W:0]    neg_re, neg_im;

    logic                      div_start, div_neg, div_done, div_sat;
    logic [63:0]               div_mag;
    logic signed [DATA_W-1:0]  div_q;

    assign sp_m1 = sp_reg - SPW'(1);
    assign sp_m2 = sp_reg - SPW'(2);
    assign rd_re = mem_rdata[2*DATA_W-1:DATA_W];
    assign rd_im = mem_rdata[DATA_W-1:0];
    assign s_ready = (state_reg == S_IDLE);
    assign mem_we  = (state_reg == S_WR);
    assign n_prod  = (kind_reg == KIND_DIV) ? 3'd6 : 3'd4;
    assign cap_fire = (state_reg == S_CAP) && (!m_valid || m_ready);

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = sp_m1[AW-1:0];
        case (state_reg)
            S_DECODE, S_TOP_RD: mem_re = 1'b1;
            S_GET_TOP: begin
                mem_re    = 1'b1;
                mem_raddr = sp_m2[AW-1:0];
            end
            default: mem_re = 1'b0;
        endcase
    end

    always_comb begin
        case (step_reg)
            3'd0: begin mul_x = a_reg; mul_y = c_reg; end
            3'd1: begin mul_x = b_reg; mul_y = d_reg; end
            3'd2: begin mul_x = a_reg; mul_y = d_reg; end
            3'd3: begin mul_x = b_reg; mul_y = c_reg; end
            3'd4: begin mul_x = c_reg; mul_y = c_reg; end
            default: begin mul_x = d_reg; mul_y = d_reg; end
        endcase
    end

    // sign / magnitude of the two summed products
    assign re_neg = sre_reg[SW-1];
    assign im_neg = sim_reg[SW-1];
    assign re_mag = re_neg ? MAG_W'(-sre_reg) : MAG_W'(sre_reg);
    assign im_mag = im_neg ? MAG_W'(-sim_reg) : MAG_W'(sim_reg);
    assign re_rnd = (re_mag + (MAG_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign im_rnd = (im_mag + (MAG_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign re_cl  = sat_mag(re_neg, re_rnd);
    assign im_cl  = sat_mag(im_neg, im_rnd);

    assign add_re = (kind_reg == KIND_SUB) ? (DATA_W+1)'(a_reg) - (DATA_W+1)'(c_reg)
                                           : (DATA_W+1)'(a_reg) + (DATA_W+1)'(c_reg);
    assign add_im = (kind_reg == KIND_SUB) ? (DATA_W+1)'(b_reg) - (DATA_W+1)'(d_reg)
                                           : (DATA_W+1)'(b_reg) + (DATA_W+1)'(d_reg);
    assign neg_re = -(DATA_W+1)'(rd_re);
    assign neg_im = -(DATA_W+1)'(rd_im);

    assign div_start = (state_reg == S_DIV_RE) || (state_reg == S_DIV_IM);
    assign div_neg   = (state_reg == S_DIV_IM) ? im_neg : re_neg;
    assign div_mag   = (state_reg == S_DIV_IM) ? im_mag[63:0] : re_mag[63:0];

    crsc_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (2 * DATA_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wr_addr_reg),
        .wdata ({res_re_reg, res_im_reg}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    crsc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .neg     (div_neg),
        .mag     (div_mag),
        .den     (den_reg),
        .done    (div_done),
        .sat     (div_sat),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            point_re_reg <= '0;
            point_im_reg <= '0;
            m_valid      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_POINT_RE: point_re_reg <= cfg_data;
                    REG_POINT_IM: point_im_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cap_fire) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            prod_reg <= mul_x * mul_y;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg   <= kind_t'(s_kind);
                        lit_re_reg <= s_literal_re;
                        lit_im_reg <= s_literal_im;
                        if (s_first_token) begin
                            sp_reg <= '0;
                        end
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    sat_reg     <= 1'b0;
                    wr_addr_reg <= sp_reg[AW-1:0];
                    case (kind_reg)
                        KIND_PUSH, KIND_PUSHZ: begin
                            if (sp_reg >= SPW'(STACK_DEPTH)) begin
                                stat_reg  <= ST_OVER;
                                state_reg <= S_TOP_RD;
                            end else begin
                                stat_reg   <= ST_OK;
                                res_re_reg <= (kind_reg == KIND_PUSH) ? lit_re_reg
                                                                      : point_re_reg;
                                res_im_reg <= (kind_reg == KIND_PUSH) ? lit_im_reg
                                                                      : point_im_reg;
                                sp_reg     <= sp_reg + SPW'(1);
                                state_reg  <= S_WR;
                            end
                        end
                        KIND_DUP: begin
                            if (sp_reg == '0) begin
                                stat_reg  <= ST_UNDER;
                                state_reg <= S_TOP_RD;
                            end else if (sp_reg >= SPW'(STACK_DEPTH)) begin
                                stat_reg  <= ST_OVER;
                                state_reg <= S_TOP_RD;
                            end else begin
                                stat_reg  <= ST_OK;
                                state_reg <= S_GET_TOP;
                            end
                        end
                        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                            if (sp_reg < SPW'(2)) begin
                                stat_reg  <= ST_UNDER;
                                state_reg <= S_TOP_RD;
                            end else begin
                                stat_reg  <= ST_OK;
                                state_reg <= S_GET_TOP;
                            end
                        end
                        KIND_DROP: begin
                            state_reg <= S_TOP_RD;
                            if (sp_reg == '0) begin
                                stat_reg <= ST_UNDER;
                            end else begin
                                stat_reg <= ST_OK;
                                sp_reg   <= sp_m1;
                            end
                        end
                        KIND_CONJ, KIND_NEG: begin
                            if (sp_reg == '0) begin
                                stat_reg  <= ST_UNDER;
                                state_reg <= S_TOP_RD;
                            end else begin
                                stat_reg  <= ST_OK;
                                state_reg <= S_GET_TOP;
                            end
                        end
                        default: begin
                            stat_reg  <= ST_OK;
                            state_reg <= S_TOP_RD;
                        end
                    endcase
                end
                S_GET_TOP: begin
                    c_reg <= rd_re;
                    d_reg <= rd_im;
                    case (kind_reg)
                        KIND_DUP: begin
                            res_re_reg <= rd_re;
                            res_im_reg <= rd_im;
                            sp_reg     <= sp_reg + SPW'(1);
                            state_reg  <= S_WR;
                        end
                        KIND_CONJ, KIND_NEG: begin
                            wr_addr_reg <= sp_m1[AW-1:0];
                            res_im_reg  <= (neg_im[DATA_W] != neg_im[DATA_W-1]) ?
                                           VAL_MAX : neg_im[DATA_W-1:0];
                            if (kind_reg == KIND_NEG) begin
                                res_re_reg <= (neg_re[DATA_W] != neg_re[DATA_W-1]) ?
                                              VAL_MAX : neg_re[DATA_W-1:0];
                            end else begin
                                res_re_reg <= rd_re;
                            end
                            // only the most negative value overflows on negation
                            sat_reg   <= (rd_im == VAL_MIN) ||
                                         ((kind_reg == KIND_NEG) && (rd_re == VAL_MIN));
                            state_reg <= S_WR;
                        end
                        default: state_reg <= S_GET_SEC;
                    endcase
                end
                S_GET_SEC: begin
                    a_reg       <= rd_re;
                    b_reg       <= rd_im;
                    wr_addr_reg <= sp_m2[AW-1:0];
                    sp_reg      <= sp_m1;
                    step_reg    <= '0;
                    state_reg   <= (kind_reg == KIND_ADD || kind_reg == KIND_SUB) ? S_ADDSUB
                                                                                  : S_MUL;
                end
                S_ADDSUB: begin
                    res_re_reg <= (add_re[DATA_W] != add_re[DATA_W-1]) ?
                                  (add_re[DATA_W] ? VAL_MIN : VAL_MAX) : add_re[DATA_W-1:0];
                    res_im_reg <= (add_im[DATA_W] != add_im[DATA_W-1]) ?
                                  (add_im[DATA_W] ? VAL_MIN : VAL_MAX) : add_im[DATA_W-1:0];
                    sat_reg    <= (add_re[DATA_W] != add_re[DATA_W-1]) ||
                                  (add_im[DATA_W] != add_im[DATA_W-1]);
                    state_reg  <= S_WR;
                end
                S_MUL: begin
                    // product of step k lands in prod_reg in the next cycle
                    if (step_reg != 3'd0) begin
                        prods_reg[step_reg - 3'd1] <= prod_reg;
                    end
                    if (step_reg == n_prod) begin
                        state_reg <= S_SUM;
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_SUM: begin
                    if (kind_reg == KIND_DIV) begin
                        sre_reg   <= SW'(prods_reg[0]) + SW'(prods_reg[1]);
                        sim_reg   <= SW'(prods_reg[3]) - SW'(prods_reg[2]);
                        den_reg   <= prods_reg[4] + prods_reg[5];
                        state_reg <= S_DIV_CHK;
                    end else begin
                        sre_reg   <= SW'(prods_reg[0]) - SW'(prods_reg[1]);
                        sim_reg   <= SW'(prods_reg[2]) + SW'(prods_reg[3]);
                        state_reg <= S_MUL_RND;
                    end
                end
                S_MUL_RND: begin
                    res_re_reg <= re_cl[DATA_W-1:0];
                    res_im_reg <= im_cl[DATA_W-1:0];
                    sat_reg    <= re_cl[DATA_W] || im_cl[DATA_W];
                    state_reg  <= S_WR;
                end
                S_DIV_CHK: begin
                    if (den_reg == '0) begin
                        res_re_reg <= (re_mag == '0) ? '0 : (re_neg ? VAL_MIN : VAL_MAX);
                        res_im_reg <= (im_mag == '0) ? '0 : (im_neg ? VAL_MIN : VAL_MAX);
                        sat_reg    <= 1'b1;
                        state_reg  <= S_WR;
                    end else begin
                        state_reg <= S_DIV_RE;
                    end
                end
                S_DIV_RE: state_reg <= S_DIV_RE_W;
                S_DIV_RE_W: begin
                    if (div_done) begin
                        res_re_reg <= div_q;
                        sat_reg    <= sat_reg | div_sat;
                        state_reg  <= S_DIV_IM;
                    end
                end
                S_DIV_IM: state_reg <= S_DIV_IM_W;
                S_DIV_IM_W: begin
                    if (div_done) begin
                        res_im_reg <= div_q;
                        sat_reg    <= sat_reg | div_sat;
                        state_reg  <= S_WR;
                    end
                end
                S_WR: state_reg <= S_TOP_RD;
                S_TOP_RD: state_reg <= S_CAP;
                S_CAP: begin
                    if (cap_fire) begin
                        m_top_re  <= (sp_reg == '0) ? '0 : rd_re;
                        m_top_im  <= (sp_reg == '0) ? '0 : rd_im;
                        m_depth   <= DEPTH_W'(sp_reg);
                        m_status  <= (stat_reg != ST_OK) ? stat_reg
                                                         : (sat_reg ? ST_SAT : ST_OK);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== dv/crsc_checker.sv =====
`timescale 1ns / 1ps

module crsc_checker
    import crsc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic [KIND_W-1:0]        s_kind,
    input  wire logic signed [DATA_W-1:0] s_literal_re,
    input  wire logic signed [DATA_W-1:0] s_literal_im,
    input  wire logic                     s_first_token,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic signed [DATA_W-1:0] m_top_re,
    input  wire logic signed [DATA_W-1:0] m_top_im,
    input  wire logic [DEPTH_W-1:0]       m_depth,
    input  wire logic [STATUS_W-1:0]      m_status,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_data,
    output int                            fail_count,
    output int                            pending
);

    localparam int NSTACK = DEF_STACK_DEPTH;
    localparam int FRAC   = DEF_FRAC_BITS;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [DEPTH_W-1:0]       depth;
        logic [STATUS_W-1:0]      status;
    } calc_result_t;

    logic signed [DATA_W-1:0] stk_re [NSTACK];
    logic signed [DATA_W-1:0] stk_im [NSTACK];
    int                       stk_ptr;
    logic signed [DATA_W-1:0] z_re, z_im;
    logic                     clamped;
    calc_result_t             expected_results [$];

    function automatic logic signed [DATA_W-1:0] clamp_sum(input wide_t v);
        if (v > wide_t'(32'sh7fffffff)) begin
            clamped = 1'b1;
            return VAL_MAX;
        end
        if (v < -wide_t'(64'sd2147483648)) begin
            clamped = 1'b1;
            return VAL_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_mag(input logic neg, input wide_t mag);
        if (neg) begin
            if (mag >= wide_t'(64'd2147483648)) begin
                if (mag > wide_t'(64'd2147483648)) clamped = 1'b1;
                return VAL_MIN;
            end
            return -mag[DATA_W-1:0];
        end
        return clamp_sum(mag);
    endfunction

    function automatic logic signed [DATA_W-1:0] round_product(input wide_t p, input wide_t q);
        wide_t s;
        wide_t mag;
        s = p + q;
        mag = (s < 0) ? -s : s;
        mag = (mag + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
        return clamp_mag(s < 0, mag);
    endfunction

    function automatic logic signed [DATA_W-1:0] round_quotient(input wide_t num,
                                                                input wide_t den);
        wide_t mag, n, q, r;
        mag = (num < 0) ? -num : num;
        if (den == 0) begin
            clamped = 1'b1;
            if (mag == 0) return '0;
            return (num < 0) ? VAL_MIN : VAL_MAX;
        end
        n = mag <<< FRAC;
        q = n / den;
        r = n % den;
        if (q > wide_t'(64'hffffffff)) begin
            clamped = 1'b1;
            return (num < 0) ? VAL_MIN : VAL_MAX;
        end
        if (r >= den - r) q = q + 1;
        return clamp_mag(num < 0, q);
    endfunction

    function automatic calc_result_t run_token(input logic [KIND_W-1:0] kind,
                                               input logic signed [DATA_W-1:0] lit_re,
                                               input logic signed [DATA_W-1:0] lit_im,
                                               input logic first);
        calc_result_t res;
        logic [STATUS_W-1:0] st;
        wide_t a, b, c, d;
        logic signed [DATA_W-1:0] r, m;
        st = ST_OK;
        clamped = 1'b0;
        if (first) stk_ptr = 0;
        case (kind)
            KIND_PUSH, KIND_PUSHZ, KIND_DUP: begin
                if (kind == KIND_DUP && stk_ptr < 1) begin
                    st = ST_UNDER;
                end else if (stk_ptr >= NSTACK) begin
                    st = ST_OVER;
                end else begin
                    if (kind == KIND_PUSH) begin
                        r = lit_re;
                        m = lit_im;
                    end else if (kind == KIND_PUSHZ) begin
                        r = z_re;
                        m = z_im;
                    end else begin
                        r = stk_re[stk_ptr-1];
                        m = stk_im[stk_ptr-1];
                    end
                    stk_re[stk_ptr] = r;
                    stk_im[stk_ptr] = m;
                    stk_ptr++;
                end
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                if (stk_ptr < 2) begin
                    st = ST_UNDER;
                end else begin
                    a = stk_re[stk_ptr-2];
                    b = stk_im[stk_ptr-2];
                    c = stk_re[stk_ptr-1];
                    d = stk_im[stk_ptr-1];
                    case (kind)
                        KIND_ADD: begin
                            r = clamp_sum(a + c);
                            m = clamp_sum(b + d);
                        end
                        KIND_SUB: begin
                            r = clamp_sum(a - c);
                            m = clamp_sum(b - d);
                        end
                        KIND_MUL: begin
                            r = round_product(a * c, -(b * d));
                            m = round_product(a * d, b * c);
                        end
                        default: begin
                            // (a+bi)/(c+di) = ((ac+bd) + (bc-ad)i) / (c^2+d^2)
                            r = round_quotient(a * c + b * d, c * c + d * d);
                            m = round_quotient(b * c - a * d, c * c + d * d);
                        end
                    endcase
                    stk_ptr--;
                    stk_re[stk_ptr-1] = r;
                    stk_im[stk_ptr-1] = m;
                end
            end
            KIND_DROP, KIND_CONJ, KIND_NEG: begin
                if (stk_ptr < 1) begin
                    st = ST_UNDER;
                end else if (kind == KIND_DROP) begin
                    stk_ptr--;
                end else begin
                    if (kind == KIND_NEG)
                        stk_re[stk_ptr-1] = clamp_sum(-wide_t'(stk_re[stk_ptr-1]));
                    stk_im[stk_ptr-1] = clamp_sum(-wide_t'(stk_im[stk_ptr-1]));
                end
            end
            default: ;
        endcase
        if (st == ST_OK && clamped) st = ST_SAT;
        res.re     = (stk_ptr > 0) ? stk_re[stk_ptr-1] : '0;
        res.im     = (stk_ptr > 0) ? stk_im[stk_ptr-1] : '0;
        res.depth  = DEPTH_W'(stk_ptr);
        res.status = st;
        return res;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        calc_result_t want;
        if (!aresetn) begin
            stk_ptr = 0;
            z_re = '0;
            z_im = '0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_POINT_RE) z_re = cfg_data;
                else if (cfg_index == REG_POINT_IM) z_im = cfg_data;
            end
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                    run_token(s_kind, s_literal_re, s_literal_im, s_first_token));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"ERROR: result transaction with nothing expected: ",
                                  "%h %h %0d %0d"},
                                 m_top_re, m_top_im, m_depth, m_status);
                end else begin
                    want = expected_results.pop_front();
                    if (want.re !== m_top_re || want.im !== m_top_im ||
                        want.depth !== m_depth || want.status !== m_status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"ERROR: exp re=%h im=%h depth=%0d st=%0d, ",
                                      "got re=%h im=%h depth=%0d st=%0d"},
                                     want.re, want.im, want.depth, want.status,
                                     m_top_re, m_top_im, m_depth, m_status);
                    end
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import crsc_pkg::*;

    localparam int  RANDOM_TOKENS = 1600;
    localparam int  DRAIN_CYCLES  = 200;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [KIND_W-1:0]        s_kind;
    logic signed [DATA_W-1:0] s_literal_re;
    logic signed [DATA_W-1:0] s_literal_im;
    logic                     s_first_token;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_top_re;
    logic signed [DATA_W-1:0] m_top_im;
    logic [DEPTH_W-1:0]       m_depth;
    logic [STATUS_W-1:0]      m_status;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    int                       fail_count;
    int                       pending;
    int                       tokens_sent;
    logic                     no_gaps;
    longint                   cycles;

    complex_rpn_stack_calculator i_dut (.*);

    crsc_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        int held;
        logic long_hold_done;
        long_hold_done = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && tokens_sent >= 400) begin
                long_hold_done = 1'b1;
                for (held = 0; held < 400; held++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= no_gaps || ($urandom_range(99) >= 33);
            @(posedge aclk);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return 32'sh0001_0000;
            4: return -32'sh0001_0000;
            5, 6: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            7: return $signed($urandom_range(32'h0000_0400)) - 32'sh0000_0200;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_token(input logic [KIND_W-1:0] kind,
                              input logic signed [DATA_W-1:0] lit_re,
                              input logic signed [DATA_W-1:0] lit_im,
                              input logic first);
        while (!no_gaps && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            s_kind <= KIND_W'($urandom());
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_literal_re  <= lit_re;
        s_literal_im  <= lit_im;
        s_first_token <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tokens_sent++;
    endtask

    task automatic push_lit(input logic signed [DATA_W-1:0] re,
                            input logic signed [DATA_W-1:0] im, input logic first);
        send_token(KIND_PUSH, re, im, first);
    endtask

    task automatic op(input kind_t kind);
        send_token(kind, $urandom(), $urandom(), 1'b0);
    endtask

    // settle the block, then load a new evaluation point
    task automatic set_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POINT_RE;
        cfg_data  <= re;
        @(posedge aclk);
        cfg_index <= REG_POINT_IM;
        cfg_data  <= im;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_token();
        logic [KIND_W-1:0] kind;
        int w;
        w = $urandom_range(99);
        if (w < 26)      kind = KIND_PUSH;
        else if (w < 34) kind = KIND_PUSHZ;
        else if (w < 42) kind = KIND_ADD;
        else if (w < 50) kind = KIND_SUB;
        else if (w < 60) kind = KIND_MUL;
        else if (w < 68) kind = KIND_DIV;
        else if (w < 77) kind = KIND_DUP;
        else if (w < 87) kind = KIND_DROP;
        else if (w < 92) kind = KIND_CONJ;
        else if (w < 97) kind = KIND_NEG;
        else             kind = KIND_W'($urandom_range(15, 10));
        send_token(kind, pick_value(), pick_value(), $urandom_range(39) == 0);
    endtask

    initial begin
        int n;
        int phase;
        cycles        = 0;
        tokens_sent   = 0;
        no_gaps       = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = '0;
        s_literal_re  = '0;
        s_literal_im  = '0;
        s_first_token = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_point(32'h0001_8000, 32'hffff_4000);
        // empty stack, underflow on add, dup, drop and neg
        op(KIND_ADD);
        op(KIND_DUP);
        op(KIND_DROP);
        op(KIND_NEG);
        send_token(KIND_W'(15), '0, '0, 1'b0);
        push_lit(VAL_MAX, VAL_MIN, 1'b1);
        push_lit(VAL_MAX, VAL_MIN, 1'b0);
        op(KIND_ADD);
        op(KIND_NEG);
        op(KIND_CONJ);
        op(KIND_PUSHZ);
        op(KIND_MUL);
        op(KIND_PUSHZ);
        op(KIND_DIV);
        push_lit('0, '0, 1'b0);
        op(KIND_DIV);
        push_lit(32'sh0000_0001, -32'sh0000_0001, 1'b0);
        op(KIND_SUB);
        // fill past the top to hit overflow
        for (n = 0; n < 17; n++) op(KIND_DUP);
        op(KIND_PUSH);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_point(VAL_MAX, VAL_MIN);
                1: set_point(VAL_MIN, VAL_MAX);
                2: set_point('0, '0);
                default: set_point($urandom(), $urandom());
            endcase
            for (n = 0; n < RANDOM_TOKENS / 4; n++) begin
                no_gaps = (phase == 2 && n >= 100 && n < 250);
                random_token();
            end
        end
        no_gaps = 1'b0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
